/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the reverse delay block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Same-cycle implication check failed.");

// Next-cycle implication, checked only while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Next-cycle implication check failed.");

`endif

/* rtl/pprd_pkg.sv */
`timescale 1ns / 1ps

package pprd_pkg;

	localparam int MAX_CHUNK = 65536;
	localparam int CHANNELS = 2;

	localparam int SAMPLE_W = 24;
	localparam int FRAC_W = 16;
	localparam int GAIN_W = FRAC_W + 1;
	localparam int CF_W = 16;
	localparam int FBG_W = 16;
	localparam int CHUNK_W = 17;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int POS_W = $clog2(MAX_CHUNK);
	localparam int LEN_W = $clog2(MAX_CHUNK + 1);
	localparam int ADDR_W = POS_W + 1;
	localparam int LANE_DEPTH = 1 << ADDR_W;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << FRAC_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [GAIN_W-1:0] gain_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		logic  wr_zero;
		logic  mul_en;
	} lane_ctl_t;

	typedef enum logic [1:0] {
		REG_CHUNK_LENGTH     = 2'd0,
		REG_CROSSFADE_LENGTH = 2'd1,
		REG_FEEDBACK_GAIN    = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_MUL   = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

endpackage

/* rtl/pprd_in_if.sv */
`timescale 1ns / 1ps

interface pprd_in_if;
	logic valid;
	logic ready;
	pprd_pkg::sample_t in_left;
	pprd_pkg::sample_t in_right;

	modport source (output valid, output in_left, output in_right, input ready);
	modport sink (input valid, input in_left, input in_right, output ready);
endinterface

/* rtl/pprd_out_if.sv */
`timescale 1ns / 1ps

interface pprd_out_if;
	logic valid;
	logic ready;
	pprd_pkg::sample_t out_left;
	pprd_pkg::sample_t out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

/* rtl/ping_pong_reverse_delay_unit.sv */
// Reverse delay with two banks of stereo samples: while one bank captures the incoming
// chunk, the other plays back the previous chunk in reverse, with an optional crossfade
// at the chunk edges and feedback of the played sample into the capture. One lane per
// channel owns its own sample store; a shared sequencer and gain divider drive the lanes,
// and a merging output register collects their samples into one result transaction. Each
// transaction is accepted and reads the play bank, waits for the one-bit-per-cycle
// crossfade gain divider when a ramp applies, multiplies, then writes the capture bank
// and loads the output register, waiting while that register is full; no new sample is
// taken until then. After reset a clearing pass writes zero to every one of the 131072
// entries of each lane store, one entry per cycle, and no transaction is taken until it
// is finished; configuration writes are taken throughout. Registers on the APB port:
// chunk_length at 0x0, crossfade_length at 0x4 and feedback_gain at 0x8.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ping_pong_reverse_delay_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pprd_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [pprd_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [pprd_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	pprd_in_if.sink                              frame,
	pprd_out_if.source                           result
);

	localparam int POS_W = pprd_pkg::POS_W;
	localparam int LEN_W = pprd_pkg::LEN_W;
	localparam int CF_W = pprd_pkg::CF_W;
	localparam int CHUNK_W = pprd_pkg::CHUNK_W;
	localparam int CMP_W = (LEN_W > CHUNK_W) ? LEN_W : CHUNK_W;
	localparam int W2 = ((POS_W > CF_W) ? POS_W : CF_W) + 1;

	pprd_pkg::state_t          state_q;
	pprd_pkg::reg_idx_t        reg_idx;
	logic [CHUNK_W-1:0]        chunk_q;
	logic [CF_W-1:0]           xfade_q;
	logic [pprd_pkg::FBG_W-1:0] fbg_q;
	logic [POS_W-1:0]          pos_q;
	logic [LEN_W-1:0]          active_q;
	logic                      bank_q;
	pprd_pkg::addr_t           clr_addr_q;
	logic                      ramp_q;
	pprd_pkg::gain_t           gain_q;
	pprd_pkg::sample_t         x_q [pprd_pkg::CHANNELS];
	pprd_pkg::sample_t         lane_y [pprd_pkg::CHANNELS];

	logic                      cfg_wr;
	logic                      in_acc;
	logic [CMP_W-1:0]          chunk_w;
	logic [LEN_W-1:0]          chunk_clamped;
	logic [LEN_W-1:0]          act_now;
	logic [W2-1:0]             pos_w2;
	logic [W2-1:0]             cf_w2;
	logic [W2-1:0]             act_w2;
	logic [W2-1:0]             rd_w2;
	logic                      fade_in;
	logic                      fade_out;
	logic                      ramp_now;
	logic [CF_W-1:0]           numer;
	logic                      div_busy;
	logic [pprd_pkg::FRAC_W-1:0] quot;
	logic                      out_free;
	logic                      fin;
	logic [LEN_W-1:0]          pos_next;
	pprd_pkg::lane_ctl_t       ctl;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = pprd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= CHUNK_W'(65536);
			xfade_q <= '0;
			fbg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				pprd_pkg::REG_CHUNK_LENGTH: begin
					chunk_q <= pwdata[CHUNK_W-1:0];
				end
				pprd_pkg::REG_CROSSFADE_LENGTH: begin
					xfade_q <= pwdata[CF_W-1:0];
				end
				pprd_pkg::REG_FEEDBACK_GAIN: begin
					fbg_q <= pwdata[pprd_pkg::FBG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pprd_pkg::REG_CHUNK_LENGTH:     prdata = pprd_pkg::APB_DATA_W'(chunk_q);
			pprd_pkg::REG_CROSSFADE_LENGTH: prdata = pprd_pkg::APB_DATA_W'(xfade_q);
			pprd_pkg::REG_FEEDBACK_GAIN:    prdata = pprd_pkg::APB_DATA_W'(fbg_q);
			default:                        prdata = '0;
		endcase
	end

	// Chunk length and crossfade decisions for the transaction being accepted.
	assign chunk_w = CMP_W'(chunk_q);

	always_comb begin
		priority if (chunk_w == '0) begin
			chunk_clamped = LEN_W'(1);
		end else if (chunk_w > CMP_W'(pprd_pkg::MAX_CHUNK)) begin
			chunk_clamped = LEN_W'(pprd_pkg::MAX_CHUNK);
		end else begin
			chunk_clamped = chunk_w[LEN_W-1:0];
		end
	end

	assign act_now = (pos_q == '0) ? chunk_clamped : active_q;
	assign pos_w2 = W2'(pos_q);
	assign cf_w2 = W2'(xfade_q);
	assign act_w2 = W2'(act_now);
	assign rd_w2 = act_w2 - W2'(1) - pos_w2;
	assign fade_in = pos_w2 < cf_w2;
	assign fade_out = (pos_w2 + cf_w2) >= act_w2;
	assign ramp_now = (xfade_q != '0) && (fade_in || fade_out);
	assign numer = CF_W'(fade_in ? pos_w2 : rd_w2);

	assign frame.ready = state_q == pprd_pkg::S_IDLE;
	assign in_acc = frame.valid && frame.ready;
	assign fin = (state_q == pprd_pkg::S_WRITE) && out_free;
	assign pos_next = LEN_W'(pos_q) + LEN_W'(1);

	pprd_gain_div u_gain_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc && ramp_now),
		.numer  (numer),
		.denom  (xfade_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pprd_pkg::S_CLEAR;
			clr_addr_q <= '0;
			pos_q <= '0;
			active_q <= LEN_W'(pprd_pkg::MAX_CHUNK);
			bank_q <= 1'b0;
			ramp_q <= 1'b0;
		end else begin
			unique case (state_q)
				pprd_pkg::S_CLEAR: begin
					clr_addr_q <= clr_addr_q + pprd_pkg::ADDR_W'(1);
					if (&clr_addr_q) begin
						state_q <= pprd_pkg::S_IDLE;
					end
				end
				pprd_pkg::S_IDLE: begin
					if (in_acc) begin
						active_q <= act_now;
						ramp_q <= ramp_now;
						state_q <= pprd_pkg::S_DIV;
					end
				end
				pprd_pkg::S_DIV: begin
					if (!ramp_q || !div_busy) begin
						state_q <= pprd_pkg::S_MUL;
					end
				end
				pprd_pkg::S_MUL: begin
					state_q <= pprd_pkg::S_WRITE;
				end
				pprd_pkg::S_WRITE: begin
					if (out_free) begin
						if (pos_next >= active_q) begin
							pos_q <= '0;
							bank_q <= !bank_q;
						end else begin
							pos_q <= pos_next[POS_W-1:0];
						end
						state_q <= pprd_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= pprd_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q[0] <= frame.in_left;
			if (pprd_pkg::CHANNELS > 1) begin
				x_q[pprd_pkg::CHANNELS-1] <= frame.in_right;
			end
		end
		if ((state_q == pprd_pkg::S_DIV) && (!ramp_q || !div_busy)) begin
			gain_q <= ramp_q ? {1'b0, quot} : pprd_pkg::UNITY_GAIN;
		end
	end

	always_comb begin
		ctl.rd_en = in_acc;
		ctl.rd_addr = {!bank_q, rd_w2[POS_W-1:0]};
		ctl.mul_en = state_q == pprd_pkg::S_MUL;
		ctl.wr_zero = state_q == pprd_pkg::S_CLEAR;
		ctl.wr_en = ctl.wr_zero || fin;
		ctl.wr_addr = ctl.wr_zero ? clr_addr_q : {bank_q, pos_q};
	end

	for (genvar g = 0; g < pprd_pkg::CHANNELS; g++) begin : g_lane
		pprd_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.x       (x_q[g]),
			.gain    (gain_q),
			.fb_gain (fbg_q),
			.y       (lane_y[g])
		);
	end

	pprd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fin),
		.lane_y (lane_y),
		.free   (out_free),
		.result (result)
	);

	`ASSERT_IMPL(a_pos_below_active, clk, arst_n, 1'b1, LEN_W'(pos_q) < active_q)
	`ASSERT_NEXT(a_accept_enters_div, clk, arst_n, in_acc, state_q == pprd_pkg::S_DIV)
	`ASSERT_NEXT(a_ramp_starts_div, clk, arst_n, in_acc && ramp_now, div_busy)
	`ASSERT_NEXT(a_finish_shows_result, clk, arst_n, fin, result.valid)

endmodule

/* rtl/pprd_ram.sv */
`timescale 1ns / 1ps

module pprd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/pprd_gain_div.sv */
`timescale 1ns / 1ps

module pprd_gain_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pprd_pkg::CF_W-1:0]     numer,
	input  logic [pprd_pkg::CF_W-1:0]     denom,
	output logic                          busy,
	output logic [pprd_pkg::FRAC_W-1:0]   quot
);

	localparam int CNT_W = $clog2(pprd_pkg::FRAC_W + 1);

	logic [CNT_W-1:0]              count_q;
	logic [pprd_pkg::CF_W-1:0]     rem_q;
	logic [pprd_pkg::CF_W-1:0]     denom_q;
	logic [pprd_pkg::FRAC_W-1:0]   quot_q;
	logic [pprd_pkg::CF_W:0]       trial;
	logic [pprd_pkg::CF_W:0]       diff;
	logic                          fits;

	// The numerator is always below the denominator, so the remainder fits its width.
	assign trial = {rem_q, 1'b0};
	assign fits = trial >= {1'b0, denom_q};
	assign diff = trial - {1'b0, denom_q};
	assign busy = count_q != '0;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CNT_W'(pprd_pkg::FRAC_W);
		end else if (busy) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			denom_q <= denom;
			quot_q <= '0;
		end else if (busy) begin
			rem_q <= fits ? diff[pprd_pkg::CF_W-1:0] : trial[pprd_pkg::CF_W-1:0];
			quot_q <= {quot_q[pprd_pkg::FRAC_W-2:0], fits};
		end
	end

endmodule

/* rtl/pprd_lane.sv */
`timescale 1ns / 1ps

module pprd_lane (
	input  logic                          clk,
	input  pprd_pkg::lane_ctl_t           ctl,
	input  pprd_pkg::sample_t             x,
	input  pprd_pkg::gain_t               gain,
	input  logic [pprd_pkg::FBG_W-1:0]    fb_gain,
	output pprd_pkg::sample_t             y
);

	localparam int SW = pprd_pkg::SAMPLE_W;
	localparam int PROD_W = SW + pprd_pkg::GAIN_W + 1;

	logic [SW-1:0]               rev_raw;
	pprd_pkg::sample_t           rev;
	logic signed [PROD_W-1:0]    fb_s1;
	logic signed [PROD_W-1:0]    y_s1;
	pprd_pkg::sample_t           fb_v;
	logic signed [SW:0]          sum_w;
	pprd_pkg::sample_t           cap_v;
	logic [SW-1:0]               wr_data;

	pprd_ram #(
		.WIDTH (SW),
		.DEPTH (pprd_pkg::LANE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (ctl.wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (ctl.rd_addr),
		.rd_data (rev_raw)
	);

	assign rev = $signed(rev_raw);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			fb_s1 <= PROD_W'(rev) * PROD_W'($signed({2'b00, fb_gain}));
			y_s1 <= PROD_W'(rev) * PROD_W'($signed({1'b0, gain}));
		end
	end

	// Dropping the fraction bits of a signed product rounds towards minus infinity.
	assign fb_v = $signed(fb_s1[pprd_pkg::FRAC_W +: SW]);
	assign y = $signed(y_s1[pprd_pkg::FRAC_W +: SW]);
	assign sum_w = $signed({x[SW-1], x}) + $signed({fb_v[SW-1], fb_v});

	always_comb begin
		if (sum_w[SW] != sum_w[SW-1]) begin
			cap_v = sum_w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			cap_v = sum_w[SW-1:0];
		end
	end

	assign wr_data = ctl.wr_zero ? '0 : cap_v;

endmodule

/* rtl/pprd_merge.sv */
`timescale 1ns / 1ps

module pprd_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  pprd_pkg::sample_t     lane_y [pprd_pkg::CHANNELS],
	output logic                  free,
	pprd_out_if.source            result
);

	logic valid_q;

	assign free = !valid_q || result.ready;
	assign result.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.out_left <= lane_y[0];
			result.out_right <= (pprd_pkg::CHANNELS > 1) ? lane_y[pprd_pkg::CHANNELS-1] : '0;
		end
	end

endmodule
